>>> design/abst_pkg.sv
// Shared types, codes and constants for the array binary search tree.
package abst_pkg;

	localparam int unsigned TreeLevelsDefault = 5;
	localparam int unsigned KeyW = 32;
	localparam int unsigned SlotW = 5;
	localparam int unsigned StatusW = 3;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_FIND   = 2'd1,
		OP_MAX    = 2'd2,
		OP_MIN    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_DONE     = 3'd0,
		ST_DUP      = 3'd1,
		ST_NOROOM   = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	// Walk token handed from one level cell to the next.
	typedef struct packed {
		logic             active;   // walk still searching
		logic             done;     // result settled
		op_t              op;
		logic [KeyW-1:0]  key;
		logic [SlotW-1:0] slot;
		logic [KeyW-1:0]  value;
		status_t          status;
	} walk_t;

	typedef enum logic [1:0] {
		CTL_IDLE,
		CTL_WALK,
		CTL_OUT
	} ctl_state_t;

endpackage

>>> design/abst_cell.sv
// One tree level: holds the keys of that level and advances the walk token.
module abst_cell #(
	parameter int unsigned LEVEL = 0,
	parameter int unsigned LEVELS = abst_pkg::TreeLevelsDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear,     // start of a new item
	input  logic              step,      // this cell's turn
	input  logic [LEVELS-1:0] pos_in,    // path bits so far: slot = 1 followed by pos
	input  abst_pkg::walk_t   walk_in,
	output logic [LEVELS-1:0] pos_out,
	output abst_pkg::walk_t   walk_out,
	output logic              root_valid
);

	localparam int unsigned N = 1 << LEVEL;
	localparam int unsigned IW = (LEVEL == 0) ? 1 : LEVEL;

	logic [abst_pkg::KeyW-1:0] keys_q [N];
	logic [N-1:0]              valid_q;
	logic [IW-1:0]             idx;
	logic [LEVELS:0]           slot_full;
	logic                      here_valid;
	logic [abst_pkg::KeyW-1:0] here_key;
	logic                      lt, eq;
	logic                      is_last;

	assign idx = (LEVEL == 0) ? '0 : pos_in[IW-1:0];
	assign here_valid = valid_q[idx];
	assign here_key = keys_q[idx];
	assign lt = $signed(walk_in.key) < $signed(here_key);
	assign eq = walk_in.key == here_key;
	assign is_last = (LEVEL == LEVELS - 1);
	assign slot_full = ({1'b1, pos_in} & (((LEVELS+1)'(1) << (LEVEL + 1)) - 1'b1))
		| ((LEVELS+1)'(1) << LEVEL);
	assign root_valid = valid_q[0];

	// Advance the walk token.
	always_comb begin
		walk_out = walk_in;
		pos_out = pos_in;
		if (step && walk_in.active && !walk_in.done) begin
			if (walk_in.op == abst_pkg::OP_INSERT || walk_in.op == abst_pkg::OP_FIND) begin
				if (!here_valid) begin
					walk_out.done = 1'b1;
					if (walk_in.op == abst_pkg::OP_INSERT) begin
						walk_out.slot = abst_pkg::SlotW'(slot_full);
						walk_out.value = walk_in.key;
						walk_out.status = abst_pkg::ST_DONE;
					end else begin
						walk_out.slot = '0;
						walk_out.value = '0;
						walk_out.status = abst_pkg::ST_NOTFOUND;
					end
				end else if (eq) begin
					walk_out.done = 1'b1;
					walk_out.slot = abst_pkg::SlotW'(slot_full);
					walk_out.value = here_key;
					walk_out.status = (walk_in.op == abst_pkg::OP_INSERT) ?
						abst_pkg::ST_DUP : abst_pkg::ST_DONE;
				end else if (is_last) begin
					walk_out.done = 1'b1;
					walk_out.slot = '0;
					walk_out.value = '0;
					walk_out.status = (walk_in.op == abst_pkg::OP_INSERT) ?
						abst_pkg::ST_NOROOM : abst_pkg::ST_NOTFOUND;
				end else begin
					pos_out = (pos_in << 1) | LEVELS'(!lt);
				end
			end else begin
				// Max/min: stop at the first empty slot, keep the previous one.
				if (!here_valid) begin
					walk_out.done = 1'b1;
					walk_out.status = (LEVEL == 0) ? abst_pkg::ST_EMPTY : abst_pkg::ST_DONE;
				end else begin
					walk_out.slot = abst_pkg::SlotW'(slot_full);
					walk_out.value = here_key;
					walk_out.status = abst_pkg::ST_DONE;
					if (is_last) begin
						walk_out.done = 1'b1;
					end else begin
						pos_out = (pos_in << 1)
							| LEVELS'(walk_in.op == abst_pkg::OP_MAX);
					end
				end
			end
		end
	end

	// Store an inserted key in the empty slot that the walk reaches on this level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (step && walk_in.active && !walk_in.done && !here_valid
				&& walk_in.op == abst_pkg::OP_INSERT) begin
			valid_q[idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (step && walk_in.active && !walk_in.done && !here_valid
				&& walk_in.op == abst_pkg::OP_INSERT) begin
			keys_q[idx] <= walk_in.key;
		end
	end

	logic unused;
	assign unused = clear;

endmodule

>>> design/array_binary_search_tree_top.sv
// Top level of the array binary search tree: stream ports and level chain.
// Each item walks one cell per tree level, one level per cycle, starting at
// the root: the item is loaded into the walk register, steps through the
// chain of level cells until its result settles or the last level is done,
// and is then held at the output until it is taken.
// One item is worked at a time. Slot 0 is unused; slots above 31 report only
// their low five bits.
module array_binary_search_tree_top #(
	parameter int unsigned TREE_LEVELS = abst_pkg::TreeLevelsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // op[1:0], key[33:2], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // slot[4:0], value[36:5], status[39:37]
);

	localparam int unsigned LW = $clog2(TREE_LEVELS + 1);

	abst_pkg::ctl_state_t state_q, state_d;
	abst_pkg::walk_t      walk_q;
	logic [TREE_LEVELS-1:0] pos_q;
	logic [LW-1:0]        lvl_q;
	abst_pkg::walk_t      w_out [TREE_LEVELS];
	logic [TREE_LEVELS-1:0] p_out [TREE_LEVELS];
	logic [TREE_LEVELS-1:0] rv;
	logic                 accept, walking, finish;

	assign accept = s_tvalid && s_tready;
	assign walking = (state_q == abst_pkg::CTL_WALK);

	// Level cells, each stepped on its own cycle.
	for (genvar g = 0; g < TREE_LEVELS; g++) begin : g_lvl
		abst_cell #(.LEVEL(g), .LEVELS(TREE_LEVELS)) u_cell (
			.clk(clk), .arst_n(arst_n), .clear(accept),
			.step(walking && lvl_q == LW'(g)),
			.pos_in(pos_q), .walk_in(walk_q),
			.pos_out(p_out[g]), .walk_out(w_out[g]), .root_valid(rv[g])
		);
	end

	assign finish = walking && (w_out[lvl_q[$clog2(TREE_LEVELS)-1:0]].done
		|| lvl_q == LW'(TREE_LEVELS - 1));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			abst_pkg::CTL_IDLE: if (accept) state_d = abst_pkg::CTL_WALK;
			abst_pkg::CTL_WALK: if (finish) state_d = abst_pkg::CTL_OUT;
			abst_pkg::CTL_OUT:  if (m_tready) state_d = abst_pkg::CTL_IDLE;
			default:            state_d = abst_pkg::CTL_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		s_tready = (state_q == abst_pkg::CTL_IDLE);
		m_tvalid = (state_q == abst_pkg::CTL_OUT);
		m_tdata = {walk_q.status, walk_q.value, walk_q.slot};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= abst_pkg::CTL_IDLE;
			lvl_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) lvl_q <= '0;
			else if (walking) lvl_q <= lvl_q + 1'b1;
		end
	end

	// Load or advance the walk token.
	always_ff @(posedge clk) begin
		if (accept) begin
			walk_q.active <= 1'b1;
			walk_q.done <= 1'b0;
			walk_q.op <= abst_pkg::op_t'(s_tdata[1:0]);
			walk_q.key <= s_tdata[33:2];
			walk_q.slot <= '0;
			walk_q.value <= '0;
			walk_q.status <= abst_pkg::ST_EMPTY;
			pos_q <= '0;
		end else if (walking) begin
			walk_q <= w_out[lvl_q[$clog2(TREE_LEVELS)-1:0]];
			pos_q <= p_out[lvl_q[$clog2(TREE_LEVELS)-1:0]];
		end
	end

	logic unused;
	assign unused = ^rv ^ (^s_tdata[39:34]);

	// Checks.
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("ready while result pending");
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		walking |-> lvl_q < LW'(TREE_LEVELS)) else $error("walk past last level");
	a_out_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(walking)) else $error("result without walk");

endmodule
